// ===== rtl/assert_macros.svh =====
// Assertion helpers for the spanning tree block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property with reset gating.
`define KMST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds during reset.
`define KMST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/kmst_pkg.sv =====
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types, defaults and helpers for the spanning tree block.
// ----------------------------------------------------------------------------
package kmst_pkg;

  localparam int MaxVerticesDef = 64;
  localparam int MaxEdgesDef    = 256;

  localparam int VcW   = 7;   // vertex_count register width
  localparam int VtxW  = 6;
  localparam int CostW = 16;
  localparam int TotW  = 22;

  localparam logic [VcW-1:0] VcReset = 7'd64;

  typedef struct packed {
    logic signed [CostW-1:0] cost;
    logic [VtxW-1:0]         dst;
    logic [VtxW-1:0]         src;
  } edge_t;

  // Endpoint outside the vertices in use.
  function automatic logic edge_stale(edge_t e, logic [VcW-1:0] nv);
    return ({1'b0, e.src} >= nv) || ({1'b0, e.dst} >= nv);
  endfunction

endpackage

// ===== rtl/kruskal_min_spanning_tree.sv =====
// ----------------------------------------------------------------------------
// kruskal_min_spanning_tree
// Minimum spanning forest: edge store, in-place insertion sort, union-find.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis: one edge per beat, tdata = {cost, to, from}, tlast marks the last
//    edge of a graph. An edge with an endpoint >= max(vertex_count, 1), or
//    one that arrives with the store full, is dropped and sets the dropped flag.
//  m_axis: one beat per accepted tree edge, tdata = {running_total, cost,
//    to, from}, tuser = {dropped, edge_valid}, tlast on the final beat. An
//    empty forest gives one beat with edge_valid low.
//  cfg: vertex_count write, taken any time, meant for idle periods.
// Loading: one edge per cycle while idle. After tlast the block is busy:
//  an in-place insertion sort orders the stored edges by cost, then a walk
//  takes them in order, skips stale ones, finds the root of each endpoint by
//  parent hops and joins distinct roots, then the last result is flushed.
//  s_axis_tready is low after the tlast beat until the last result sits in
//  the output register.
// Reset: fill count, drop flag and union-find valid bits clear at once; no
//  clearing pass. A stalled receiver holds the sequencer at the next result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kruskal_min_spanning_tree import kmst_pkg::*; #(
  parameter int MAX_VERTICES = MaxVerticesDef,
  parameter int MAX_EDGES    = MaxEdgesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [5:0] edge_from, [11:6] edge_to, [27:12] edge_cost
  input  logic        s_axis_tlast_i,   // final_edge
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // [5:0] tree_from, [11:6] tree_to,
                                        // [27:12] tree_cost, [49:28] running_total
  output logic [1:0]  m_axis_tuser_o,   // [0] edge_valid, [1] dropped_flag
  output logic        m_axis_tlast_o,   // last_result
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i        // vertex_count
);

  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW  = $clog2(MAX_EDGES + 1);
  localparam int VIW = $clog2(MAX_VERTICES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SI_RD  = 4'd1;
  localparam logic [3:0] S_SI_E   = 4'd2;
  localparam logic [3:0] S_SJ_RD  = 4'd3;
  localparam logic [3:0] S_SJ_CMP = 4'd4;
  localparam logic [3:0] S_W_RD   = 4'd5;
  localparam logic [3:0] S_W_E    = 4'd6;
  localparam logic [3:0] S_FA_RD  = 4'd7;
  localparam logic [3:0] S_FA_CK  = 4'd8;
  localparam logic [3:0] S_FB_RD  = 4'd9;
  localparam logic [3:0] S_FB_CK  = 4'd10;
  localparam logic [3:0] S_UNI    = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0]     st_q;
  logic [VcW-1:0] vc_q, nv;
  logic [FW-1:0]  fill_q, i_q, j_q, k_q, i_inc, j_dec;
  logic [VcW-1:0] acc_q;
  logic           drop_q;
  edge_t          e_q, rd_q, in_edge, pend_q;
  logic signed [TotW-1:0] total_q, total_nx;
  logic           pend_v_q;
  logic [VIW-1:0] x_q, ra_q, rb_q, par;
  logic           out_v_q, out_last_q;
  logic [55:0]    out_data_q;
  logic [1:0]     out_user_q;

  // edge store and union-find parent memory
  edge_t          emem [MAX_EDGES];
  logic [VIW-1:0] pmem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pv_q;
  logic [VIW-1:0] pdat_q;
  logic           pval_q;

  logic           e_we, p_we, in_ok, s_fire, slot_ok, gt, out_set;
  logic [EIW-1:0] e_waddr, e_raddr;
  edge_t          e_wdata;

  assign nv = (vc_q == '0) ? VcW'(1) :
              ((vc_q > VcW'(MAX_VERTICES)) ? VcW'(MAX_VERTICES) : vc_q);

  assign in_edge = edge_t'(s_axis_tdata_i[27:0]);
  assign s_axis_tready_o = (st_q == S_IDLE);
  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_ok   = !edge_stale(in_edge, nv) && (fill_q < FW'(MAX_EDGES));
  assign slot_ok = !out_v_q || m_axis_tready_i;
  assign i_inc   = i_q + FW'(1);
  assign j_dec   = j_q - FW'(1);
  assign gt      = $signed(rd_q.cost) > $signed(e_q.cost);
  assign par     = pval_q ? pdat_q : x_q;
  assign total_nx = total_q + {{(TotW-CostW){e_q.cost[CostW-1]}}, e_q.cost};
  // a new beat goes into the output register this cycle
  assign out_set = slot_ok && (((st_q == S_UNI) && (ra_q != rb_q) && pend_v_q) ||
                               (st_q == S_FIN));

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    e_we    = 1'b0;
    e_waddr = fill_q[EIW-1:0];
    e_wdata = in_edge;
    e_raddr = i_q[EIW-1:0];
    p_we    = 1'b0;
    case (st_q)
      S_IDLE: e_we = s_fire && in_ok;
      S_SI_RD: e_raddr = i_q[EIW-1:0];
      S_SJ_RD: begin
        if (j_q == '0) begin
          e_we    = 1'b1;
          e_waddr = '0;
          e_wdata = e_q;
        end else begin
          e_raddr = j_dec[EIW-1:0];
        end
      end
      S_SJ_CMP: begin
        e_we    = 1'b1;
        e_waddr = j_q[EIW-1:0];
        e_wdata = gt ? rd_q : e_q;
      end
      S_W_RD: e_raddr = k_q[EIW-1:0];
      S_UNI: p_we = (ra_q != rb_q) && slot_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (e_we) begin
      emem[e_waddr] <= e_wdata;
    end
    rd_q <= emem[e_raddr];
    if (p_we) begin
      pmem[ra_q] <= rb_q;
    end
    pdat_q <= pmem[x_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      vc_q       <= VcReset;
      fill_q     <= '0;
      drop_q     <= 1'b0;
      pv_q       <= '0;
      pval_q     <= 1'b0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_data_q <= '0;
      out_user_q <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      acc_q      <= '0;
      total_q    <= '0;
      e_q        <= '0;
      pend_q     <= '0;
      x_q        <= '0;
      ra_q       <= '0;
      rb_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        vc_q <= cfg_data_i;
      end
      if (out_set) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
      pval_q <= pv_q[x_q];
      if (p_we) begin
        pv_q[ra_q] <= 1'b1;
      end
      case (st_q)
        S_IDLE: begin
          if (s_fire) begin
            if (in_ok) begin
              fill_q <= fill_q + FW'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (s_axis_tlast_i) begin
              i_q      <= '0;
              k_q      <= '0;
              acc_q    <= '0;
              total_q  <= '0;
              pend_v_q <= 1'b0;
              st_q     <= (fill_q == '0 && !in_ok) ? S_W_RD : S_SI_RD;
            end
          end
        end
        S_SI_RD: st_q <= S_SI_E;
        S_SI_E: begin
          e_q <= rd_q;
          if (edge_stale(rd_q, nv)) begin
            drop_q <= 1'b1;
          end
          j_q  <= i_q;
          st_q <= S_SJ_RD;
        end
        S_SJ_RD: begin
          if (j_q == '0) begin
            i_q  <= i_inc;
            st_q <= (i_inc == fill_q) ? S_W_RD : S_SI_RD;
          end else begin
            st_q <= S_SJ_CMP;
          end
        end
        S_SJ_CMP: begin
          if (gt) begin
            j_q  <= j_dec;
            st_q <= S_SJ_RD;
          end else begin
            i_q  <= i_inc;
            st_q <= (i_inc == fill_q) ? S_W_RD : S_SI_RD;
          end
        end
        S_W_RD: begin
          if (k_q == fill_q || (acc_q + VcW'(1)) >= nv) begin
            st_q <= S_FIN;
          end else begin
            st_q <= S_W_E;
          end
        end
        S_W_E: begin
          e_q <= rd_q;
          if (edge_stale(rd_q, nv)) begin
            k_q  <= k_q + FW'(1);
            st_q <= S_W_RD;
          end else begin
            x_q  <= rd_q.src[VIW-1:0];
            st_q <= S_FA_RD;
          end
        end
        S_FA_RD: st_q <= S_FA_CK;
        S_FA_CK: begin
          if (par == x_q) begin
            ra_q <= x_q;
            x_q  <= e_q.dst[VIW-1:0];
            st_q <= S_FB_RD;
          end else begin
            x_q  <= par;
            st_q <= S_FA_RD;
          end
        end
        S_FB_RD: st_q <= S_FB_CK;
        S_FB_CK: begin
          if (par == x_q) begin
            rb_q <= x_q;
            st_q <= S_UNI;
          end else begin
            x_q  <= par;
            st_q <= S_FB_RD;
          end
        end
        S_UNI: begin
          if (ra_q == rb_q) begin
            k_q  <= k_q + FW'(1);
            st_q <= S_W_RD;
          end else if (slot_ok) begin
            // previous tree edge is now known not to be the last one
            if (pend_v_q) begin
              out_data_q <= {6'd0, total_q, pend_q.cost, pend_q.dst, pend_q.src};
              out_user_q <= {drop_q, 1'b1};
              out_last_q <= 1'b0;
            end
            pend_q   <= e_q;
            pend_v_q <= 1'b1;
            total_q  <= total_nx;
            acc_q    <= acc_q + VcW'(1);
            k_q      <= k_q + FW'(1);
            st_q     <= S_W_RD;
          end
        end
        S_FIN: begin
          if (slot_ok) begin
            out_last_q <= 1'b1;
            if (pend_v_q) begin
              out_data_q <= {6'd0, total_q, pend_q.cost, pend_q.dst, pend_q.src};
              out_user_q <= {drop_q, 1'b1};
            end else begin
              out_data_q <= '0;
              out_user_q <= {drop_q, 1'b0};
            end
            fill_q   <= '0;
            drop_q   <= 1'b0;
            pv_q     <= '0;
            pend_v_q <= 1'b0;
            st_q     <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `KMST_ASSERT(a_acc_bound, clk_i, rst_ni, (acc_q < nv) || (st_q == S_IDLE), "tree count overrun")
  `KMST_ASSERT_ALWAYS(a_fill_bound, clk_i, !rst_ni || (fill_q <= FW'(MAX_EDGES)), "fill overrun")
  `KMST_ASSERT(a_pend_busy, clk_i, rst_ni, pend_v_q |-> (st_q != S_IDLE), "stray pending result")

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spanning tree block: directed and random graphs are streamed
// in, a behavioral Kruskal predictor builds the expected tree beats, and the
// monitor compares every output beat against them in order.
// ----------------------------------------------------------------------------
module tb_top;
  import kmst_pkg::*;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam int WDOG = 400000;

  typedef struct packed {
    logic        last;
    logic [15:0] cost;
    logic [5:0]  dst;
    logic [5:0]  src;
  } edge_beat_t;

  typedef struct packed {
    logic        last;
    logic        dropped;
    logic        valid;
    logic [21:0] total;
    logic [15:0] cost;
    logic [5:0]  dst;
    logic [5:0]  src;
  } tree_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_valid = 1'b0, s_last = 1'b0, m_ready = 1'b0;
  logic [31:0] s_data = '0;
  logic cfg_valid = 1'b0;
  logic [6:0] cfg_data = '0;
  logic s_ready, m_valid, m_last, cfg_ready;
  logic [55:0] m_data;
  logic [1:0] m_user;
  // input beat was offered and not taken at the last rising edge
  logic s_hold = 1'b0;

  always #2 clk_i = ~clk_i;

  kruskal_min_spanning_tree dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  // predictor state
  logic [27:0] graph_edges[NE];
  int unsigned graph_fill;
  logic graph_drop;
  logic [6:0] vc_reg;
  tree_beat_t tree_q[$];

  edge_beat_t edge_q[$];
  int mismatches = 0;
  bit quiet = 0;
  bit calm = 0;
  int burst_s = 0, burst_m = 0;
  int idle_cycles = 0;

  function automatic void tree_append(tree_beat_t r);
    tree_q.insert(tree_q.size(), r);
  endfunction

  function automatic void edge_append(edge_beat_t b);
    edge_q.insert(edge_q.size(), b);
  endfunction

  function automatic int unsigned find_root(ref logic [5:0] par[NV], input int unsigned v);
    int unsigned r, n;
    r = v;
    while (par[r] != r) r = par[r];
    while (par[v] != r) begin
      n = par[v];
      par[v] = 6'(r);
      v = n;
    end
    return r;
  endfunction

  task automatic predict_tree(edge_beat_t b);
    int unsigned nv, n, acc;
    logic [27:0] srt[NE];
    logic [27:0] e;
    logic [5:0] par[NV];
    int j, ra, rb;
    logic signed [21:0] total;
    logic drp;
    tree_beat_t r;
    nv = (vc_reg == 0) ? 1 : (vc_reg > NV) ? NV : vc_reg;
    if (b.src >= nv || b.dst >= nv || graph_fill >= NE) graph_drop = 1'b1;
    else begin
      graph_edges[graph_fill] = {b.cost, b.dst, b.src};
      graph_fill++;
    end
    if (!b.last) return;
    n = graph_fill;
    for (int i = 0; i < n; i++) begin
      e = graph_edges[i];
      j = i;
      while (j > 0 && $signed(srt[j-1][27:12]) > $signed(e[27:12])) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = e;
    end
    for (int i = 0; i < n; i++)
      if (srt[i][5:0] >= nv || srt[i][11:6] >= nv) graph_drop = 1'b1;
    drp = graph_drop;
    for (int k = 0; k < NV; k++) par[k] = 6'(k);
    acc = 0;
    total = 0;
    for (int i = 0; i < n && acc + 1 < nv; i++) begin
      e = srt[i];
      if (e[5:0] >= nv || e[11:6] >= nv) continue;
      ra = find_root(par, e[5:0]);
      rb = find_root(par, e[11:6]);
      if (ra == rb) continue;
      par[ra] = 6'(rb);
      total += $signed(e[27:12]);
      r = '{last: 1'b0, dropped: drp, valid: 1'b1, total: total,
            cost: e[27:12], dst: e[11:6], src: e[5:0]};
      tree_append(r);
      acc++;
    end
    if (acc == 0) tree_append('{last: 1'b1, dropped: drp, default: '0});
    else tree_q[$].last = 1'b1;
    graph_fill = 0;
    graph_drop = 1'b0;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_hold) begin
        if (burst_s > 0) begin
          burst_s--;
          s_valid <= 1'b0;
        end else if (edge_q.size() > 0 && !quiet) begin
          if (!(s_valid) && $urandom_range(0, 9) == 0 && !calm)
            burst_s = $urandom_range(1, 7);
          if (burst_s > 0) s_valid <= 1'b0;
          else begin
            s_valid <= 1'b1;
            s_data <= {4'b0, edge_q[0].cost, edge_q[0].dst, edge_q[0].src};
            s_last <= edge_q[0].last;
            predict_tree(edge_q.pop_front());
          end
        end else s_valid <= 1'b0;
      end
      if (burst_m > 0) begin
        burst_m--;
        m_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst_m = $urandom_range(1, 7);
        m_ready <= 1'b0;
      end else m_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tree_beat_t got, want;
    if (rst_ni) begin
      s_hold <= s_valid && !s_ready;
      idle_cycles <= (s_valid && s_ready) || (m_valid && m_ready) ? 0 : idle_cycles + 1;
      if (m_valid && m_ready) begin
        got = '{last: m_last, dropped: m_user[1], valid: m_user[0],
                total: m_data[49:28], cost: m_data[27:12], dst: m_data[11:6],
                src: m_data[5:0]};
        if (tree_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected tree beat %h", got);
        end else begin
          want = tree_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("tree beat mismatch: exp %h got %h", want, got);
          end
        end
      end
      if (idle_cycles >= WDOG) begin
        $display("kruskal_min_spanning_tree verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drain();
    while (edge_q.size() > 0 || s_valid || tree_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_vc(logic [6:0] v);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    vc_reg = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // random graph: mostly in-range edges, some out of range
  task automatic add_graph(int unsigned nedge, int unsigned span);
    edge_beat_t b;
    for (int i = 0; i < nedge; i++) begin
      b.src = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, span - 1));
      b.dst = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, span - 1));
      case ($urandom_range(0, 3))
        0: b.cost = 16'(int'($urandom_range(0, 7)) - 4);
        default: b.cost = 16'($urandom);
      endcase
      b.last = (i == nedge - 1);
      edge_append(b);
    end
  endtask

  initial begin
    int unsigned span;
    vc_reg = VcReset;
    graph_fill = 0;
    graph_drop = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, self loop, ties, bad vertex, empty forest
    edge_append('{last: 1'b0, cost: 16'h8000, dst: 6'd63, src: 6'd0});
    edge_append('{last: 1'b0, cost: 16'h7fff, dst: 6'd1, src: 6'd62});
    edge_append('{last: 1'b0, cost: 16'h0005, dst: 6'd3, src: 6'd3});
    edge_append('{last: 1'b0, cost: 16'h0005, dst: 6'd2, src: 6'd1});
    edge_append('{last: 1'b0, cost: 16'h0005, dst: 6'd0, src: 6'd2});
    edge_append('{last: 1'b1, cost: 16'hffff, dst: 6'd63, src: 6'd62});
    edge_append('{last: 1'b1, cost: 16'h1234, dst: 6'd7, src: 6'd7});
    wait_drain();
    write_vc(7'd4);
    edge_append('{last: 1'b0, cost: 16'h0001, dst: 6'd9, src: 6'd0});
    edge_append('{last: 1'b0, cost: 16'h0002, dst: 6'd3, src: 6'd0});
    edge_append('{last: 1'b1, cost: 16'h0003, dst: 6'd2, src: 6'd1});
    wait_drain();
    // stored edges going stale after the register is lowered
    edge_append('{last: 1'b0, cost: 16'h0001, dst: 6'd3, src: 6'd2});
    wait_drain();
    write_vc(7'd3);
    edge_append('{last: 1'b1, cost: 16'h0004, dst: 6'd1, src: 6'd0});
    wait_drain();
    write_vc(7'd0);
    edge_append('{last: 1'b1, cost: 16'h0004, dst: 6'd0, src: 6'd0});
    wait_drain();
    write_vc(7'd127);
    // store overflow
    add_graph(260, 64);
    wait_drain();

    for (int g = 0; g < 30; g++) begin
      // no idling in the last part of the run
      if (g == 26) calm = 1;
      case (g % 5)
        0: write_vc(7'd64);
        1: write_vc(7'd1);
        2: write_vc(7'($urandom_range(2, 16)));
        3: write_vc(7'd2);
        default: write_vc(7'($urandom_range(0, 127)));
      endcase
      span = (vc_reg == 0) ? 1 : (vc_reg > 64) ? 64 : vc_reg;
      for (int k = 0; k < 2; k++) add_graph($urandom_range(1, 7), span);
      if (g == 15) begin
        quiet = 1;
        while (tree_q.size() > 0 || s_valid) @(posedge clk_i);
        quiet = 0;
      end
      wait_drain();
    end

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && tree_q.size() == 0)
      $display("kruskal_min_spanning_tree verification clean");
    else
      $display("kruskal_min_spanning_tree verification failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kmst_pkg.sv
rtl/kruskal_min_spanning_tree.sv
tb/sv/tb_top.sv
